>>> sv/sctu_pkg.sv
package sctu_pkg;

	// Default number of series terms.
	localparam int TERMS_DEF = 12;

	// Working format is signed Q5.59 in 64 bits.
	localparam logic signed [63:0] Q_ONE     = 64'sh0800_0000_0000_0000;
	localparam logic signed [63:0] Q_PI      = 64'sh1921_FB54_442D_1847;
	localparam logic signed [63:0] Q_NEG_PI  = -Q_PI;
	localparam logic signed [63:0] Q_TWO_PI  = 64'sh3243_F6A8_885A_308D;

	// Rounding bias for the final Q30 conversion, plus the offset that keeps it positive.
	localparam logic [63:0] RND_BIAS = 64'h4000_0000_1000_0000;

	// The divider retires this many quotient bits per cycle.
	localparam int DIV_RADIX_BITS = 8;
	localparam int DIV_STEPS      = 64 / DIV_RADIX_BITS;
	localparam int CNT_W          = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	// Micro-program addressing.
	localparam int PROG_LEN = 21;
	localparam int PC_W     = 5;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_START    = 5'd0;
	localparam pc_t PC_DIV_SET  = 5'd11;
	localparam pc_t PC_DIV_STEP = 5'd12;

	// Datapath operation of one control word.
	typedef enum logic [3:0] {
		OP_RED_SUB,
		OP_RED_ADD,
		OP_MSET_XX,
		OP_MSET_TF,
		OP_MUL,
		OP_ACC,
		OP_FIN_X2,
		OP_DIV_SET,
		OP_DIV_STEP,
		OP_FIN_TERM,
		OP_DONE
	} op_t;

	// Jump condition of one control word.
	typedef enum logic [1:0] {
		JC_NONE,
		JC_CNT,
		JC_TERM
	} jc_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] pp_sel;
		logic       acc_en;
		jc_t        jc;
		pc_t        target;
	} ctrl_t;

	// The program: range reduction, x*x, then one loop pass per series term after the first.
	localparam ctrl_t UCODE [PROG_LEN] = '{
		'{OP_RED_SUB,  2'd0, 1'b0, JC_NONE, PC_START},
		'{OP_RED_SUB,  2'd0, 1'b0, JC_NONE, PC_START},
		'{OP_RED_ADD,  2'd0, 1'b0, JC_NONE, PC_START},
		'{OP_RED_ADD,  2'd0, 1'b0, JC_NONE, PC_START},
		'{OP_MSET_XX,  2'd0, 1'b0, JC_NONE, PC_START},
		'{OP_MUL,      2'd0, 1'b0, JC_NONE, PC_START},
		'{OP_MUL,      2'd1, 1'b1, JC_NONE, PC_START},
		'{OP_MUL,      2'd2, 1'b1, JC_NONE, PC_START},
		'{OP_MUL,      2'd3, 1'b1, JC_NONE, PC_START},
		'{OP_ACC,      2'd0, 1'b1, JC_NONE, PC_START},
		'{OP_FIN_X2,   2'd0, 1'b0, JC_NONE, PC_START},
		'{OP_DIV_SET,  2'd0, 1'b0, JC_NONE, PC_START},
		'{OP_DIV_STEP, 2'd0, 1'b0, JC_CNT,  PC_DIV_STEP},
		'{OP_MSET_TF,  2'd0, 1'b0, JC_NONE, PC_START},
		'{OP_MUL,      2'd0, 1'b0, JC_NONE, PC_START},
		'{OP_MUL,      2'd1, 1'b1, JC_NONE, PC_START},
		'{OP_MUL,      2'd2, 1'b1, JC_NONE, PC_START},
		'{OP_MUL,      2'd3, 1'b1, JC_NONE, PC_START},
		'{OP_ACC,      2'd0, 1'b1, JC_NONE, PC_START},
		'{OP_FIN_TERM, 2'd0, 1'b0, JC_TERM, PC_DIV_SET},
		'{OP_DONE,     2'd0, 1'b0, JC_NONE, PC_START}
	};

	// Product of the next two factorial factors for term index i.
	function automatic int den_of(input int i, input logic cosine);
		int d;
		if (cosine) begin
			d = (2 * i - 1) * (2 * i);
		end else begin
			d = (2 * i) * (2 * i + 1);
		end
		return d;
	endfunction

endpackage

>>> sv/sine_cosine_taylor_unit.sv
// Each term goes through the radix-256 divider and then the shared 32x32 multiplier, sequenced by
// the micro-program. A command is accepted only while the unit is idle, one computation at a time.
// A new command is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous) clears the sequencer and drops res_valid; no clearing pass.
module sine_cosine_taylor_unit #(
	parameter int TERMS = sctu_pkg::TERMS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic               operation,
	input  logic signed [31:0] angle,
	output logic               res_valid,
	input  logic               res_ready,
	output logic signed [31:0] value
);
	import sctu_pkg::*;

	localparam int MaxDen = (2 * TERMS - 2) * (2 * TERMS - 1);
	localparam int DenW   = $clog2(MaxDen + 1);
	localparam int IdxW   = $clog2(TERMS);

	// Sequencer state.
	logic             busy_q;
	pc_t              pc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IdxW-1:0]  idx_q;
	logic             res_valid_q;
	ctrl_t            ctrl;
	logic             take_jump;
	logic             done_stall;
	logic             advance;

	// Datapath registers.
	logic                cos_q;
	logic signed [63:0]  x_q;
	logic signed [63:0]  x2_q;
	logic signed [63:0]  term_q;
	logic signed [63:0]  sum_q;
	logic [63:0]         a_q;
	logic [63:0]         b_q;
	logic                neg_q;
	logic [63:0]         pp_q;
	logic [1:0]          pp_sh_q;
	logic [127:0]        acc_q;
	logic [DenW-1:0]     den_q;
	logic [DenW-1:0]     rem_q;
	logic [63:0]         dq_q;
	logic signed [31:0]  value_q;

	// Datapath logic.
	logic [31:0]         a_part;
	logic [31:0]         b_part;
	logic [63:0]         mul_p;
	logic [127:0]        acc_add;
	logic [62:0]         mul_mag;
	logic signed [63:0]  mul_res;
	logic [63:0]         x_mag;
	logic [63:0]         term_mag;
	logic [DenW-1:0]     den_n;
	logic [DenW:0]       trial;
	logic [DenW-1:0]     rem_n;
	logic [DIV_RADIX_BITS-1:0] qbits;
	logic [63:0]         rnd_u;
	logic signed [35:0]  rnd_q;
	logic signed [31:0]  value_n;

	// Control word fetch and sequencing decisions.
	assign ctrl      = UCODE[pc_q];
	assign take_jump = ((ctrl.jc == JC_CNT) && (cnt_q != CNT_LAST))
		|| ((ctrl.jc == JC_TERM) && (idx_q != IdxW'(TERMS - 1)));
	assign done_stall = (ctrl.op == OP_DONE) && res_valid_q && !res_ready;
	assign advance    = busy_q && !done_stall;

	assign cmd_ready = !busy_q;
	assign res_valid = res_valid_q;
	assign value     = value_q;

	// One 32x32 partial product per cycle, registered and shifted into place in the next step.
	assign a_part = ctrl.pp_sel[1] ? a_q[63:32] : a_q[31:0];
	assign b_part = ctrl.pp_sel[0] ? b_q[63:32] : b_q[31:0];
	assign mul_p  = a_part * b_part;

	always_comb begin
		case (pp_sh_q)
			2'd0:    acc_add = {64'd0, pp_q};
			2'd1:    acc_add = {32'd0, pp_q, 32'd0};
			default: acc_add = {pp_q, 64'd0};
		endcase
	end

	// Q59 product rounded half up on the magnitude, sign applied afterwards.
	assign mul_mag = acc_q[121:59] + {62'd0, acc_q[58]};
	assign mul_res = neg_q ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});

	assign x_mag    = x_q[63] ? 64'(-x_q) : 64'(x_q);
	assign term_mag = term_q[63] ? 64'(-term_q) : 64'(term_q);
	assign den_n    = DenW'(den_of(int'(idx_q), cos_q));

	// Restoring division step: eight quotient bits against the narrow divisor.
	always_comb begin
		rem_n = rem_q;
		trial = '0;
		qbits = '0;
		for (int k = DIV_RADIX_BITS - 1; k >= 0; k--) begin
			trial = {rem_n, dq_q[64 - DIV_RADIX_BITS + k]};
			if (trial >= {1'b0, den_q}) begin
				trial    = trial - {1'b0, den_q};
				qbits[k] = 1'b1;
			end else begin
				qbits[k] = 1'b0;
			end
			rem_n = trial[DenW-1:0];
		end
	end

	// Final Q59 to Q30 rounding and saturation.
	always_comb begin
		rnd_u = 64'(sum_q) + RND_BIAS;
		rnd_q = $signed({1'b0, rnd_u[63:29]}) - 36'sh2_0000_0000;
		if (rnd_q > 36'sh0_7FFF_FFFF) begin
			value_n = 32'sh7FFF_FFFF;
		end else if (rnd_q < -36'sh0_8000_0000) begin
			value_n = -32'sh8000_0000;
		end else begin
			value_n = rnd_q[31:0];
		end
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= PC_START;
			cnt_q       <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				busy_q <= 1'b1;
				pc_q   <= PC_START;
			end else if (advance) begin
				if (ctrl.op == OP_DONE) begin
					busy_q <= 1'b0;
					pc_q   <= PC_START;
				end else if (take_jump) begin
					pc_q <= ctrl.target;
				end else begin
					pc_q <= pc_q + pc_t'(1);
				end
			end

			if (advance && (ctrl.op == OP_DIV_SET)) begin
				cnt_q <= '0;
			end else if (advance && (ctrl.op == OP_DIV_STEP)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			if (advance && (ctrl.op == OP_FIN_X2)) begin
				idx_q <= IdxW'(1);
			end else if (advance && (ctrl.op == OP_FIN_TERM) && take_jump) begin
				idx_q <= idx_q + IdxW'(1);
			end

			if (advance && (ctrl.op == OP_DONE)) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, loaded from an accepted command or driven by the current control word.
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			x_q   <= {angle[31], angle, 31'd0};
			cos_q <= operation;
		end else if (advance) begin
			case (ctrl.op)
				OP_RED_SUB: begin
					if (x_q > Q_PI) begin
						x_q <= x_q - Q_TWO_PI;
					end
				end
				OP_RED_ADD: begin
					if (x_q < Q_NEG_PI) begin
						x_q <= x_q + Q_TWO_PI;
					end
				end
				OP_MSET_XX: begin
					a_q   <= x_mag;
					b_q   <= x_mag;
					neg_q <= 1'b0;
					acc_q <= '0;
				end
				OP_MSET_TF: begin
					// The factor is minus the quotient, so it is negative whenever nonzero.
					a_q   <= term_mag;
					b_q   <= dq_q;
					neg_q <= term_q[63] ^ (|dq_q);
					acc_q <= '0;
				end
				OP_MUL: begin
					pp_q    <= mul_p;
					pp_sh_q <= {1'b0, ctrl.pp_sel[1]} + {1'b0, ctrl.pp_sel[0]};
					if (ctrl.acc_en) begin
						acc_q <= acc_q + acc_add;
					end
				end
				OP_ACC: begin
					acc_q <= acc_q + acc_add;
				end
				OP_FIN_X2: begin
					x2_q   <= mul_res;
					term_q <= cos_q ? Q_ONE : x_q;
					sum_q  <= cos_q ? Q_ONE : x_q;
				end
				OP_DIV_SET: begin
					den_q <= den_n;
					rem_q <= '0;
					dq_q  <= 64'(x2_q);
				end
				OP_DIV_STEP: begin
					rem_q <= rem_n;
					dq_q  <= {dq_q[63-DIV_RADIX_BITS:0], qbits};
				end
				OP_FIN_TERM: begin
					term_q <= mul_res;
					sum_q  <= sum_q + mul_res;
				end
				OP_DONE: begin
					value_q <= value_n;
				end
				default: begin
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> (busy_q && (pc_q == PC_START)))
		else $error("accepted command did not start the program");

	a_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (pc_q == PC_START))
		else $error("program counter not at start while idle");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(busy_q && (ctrl.op == OP_DONE)))
		else $error("result raised outside the final step");

	a_term_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IdxW'(TERMS - 1))
		else $error("term index beyond the last term");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (ctrl.op == OP_DONE) && res_valid && !res_ready)
		|=> (busy_q && $stable(value)))
		else $error("final step did not wait for the pending result");
`endif

endmodule

>>> tb/sv/tb_sine_cosine_taylor_unit.sv
module tb_sine_cosine_taylor_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import sctu_pkg::*;

	localparam int TERMS_N        = TERMS_DEF;
	localparam int LATENCY        = 12 + 16 * (TERMS_N - 1);
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 700;
	localparam int RANDOM_ITEMS   = 160;

	// Angles just below pi and 2*pi in Q4.28.
	localparam logic signed [31:0] PI_ANG     = 32'(Q_PI >>> 31);
	localparam logic signed [31:0] TWO_PI_ANG = 32'(Q_TWO_PI >>> 31);

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_ready;
	logic               operation;
	logic signed [31:0] angle;
	logic               res_valid;
	logic               res_ready;
	logic signed [31:0] value;

	logic signed [31:0] expected_values[$];
	logic signed [31:0] exp_value;
	int                 fail_count = 0;
	int                 snd_idle_pct = 0;
	int                 rcv_idle_pct = 0;
	bit                 hold_req = 1'b0;
	int                 quiet_cycles = 0;

	sine_cosine_taylor_unit #(
		.TERMS(TERMS_N)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.operation(operation),
		.angle    (angle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.value    (value)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Signed Q59 product, rounded half up on the magnitude, sign applied afterwards.
	function automatic logic signed [63:0] q59_mul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic         neg;
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [63:0]  r;
		logic [127:0] p;
		neg = a[63] ^ b[63];
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		p = {64'd0, ua} * {64'd0, ub};
		r = p[122:59] + {63'd0, p[58]};
		r[63] = 1'b0;
		return neg ? -$signed(r) : $signed(r);
	endfunction

	// Sine or cosine of one angle: reduce to [-pi, pi], sum the series, round to Q2.30.
	function automatic logic signed [31:0] taylor_value(input logic cosine,
			input logic signed [31:0] ang);
		logic signed [63:0] x;
		logic signed [63:0] x2;
		logic signed [63:0] term;
		logic signed [63:0] sum;
		logic signed [63:0] den;
		logic signed [63:0] f;
		logic [63:0]        u;
		logic signed [63:0] q;
		int                 i;
		x = ang;
		x = x <<< 31;
		for (i = 0; i < 2; i++) begin
			if (x > Q_PI) x = x - Q_TWO_PI;
		end
		for (i = 0; i < 2; i++) begin
			if (x < Q_NEG_PI) x = x + Q_TWO_PI;
		end
		x2 = q59_mul(x, x);
		term = cosine ? Q_ONE : x;
		sum = term;
		for (i = 1; i < TERMS_N; i++) begin
			den = cosine ? (2 * i - 1) * (2 * i) : (2 * i) * (2 * i + 1);
			f = -x2 / den;
			term = q59_mul(term, f);
			sum = sum + term;
		end
		u = sum + RND_BIAS;
		q = $signed(u >> 29) - 64'sh2_0000_0000;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[31:0];
	endfunction

	// Angle mix: full range, inside [-pi, pi], and next to the reduction boundaries.
	function automatic logic signed [31:0] rand_angle();
		logic signed [31:0] a;
		case ($urandom_range(3))
			0: a = $urandom;
			1: a = $signed($urandom_range(2 * PI_ANG)) - PI_ANG;
			2: a = PI_ANG + $signed($urandom_range(4)) - 2;
			default: a = TWO_PI_ANG + $signed($urandom_range(6)) - 3;
		endcase
		if ($urandom_range(1)) a = -a;
		return a;
	endfunction

	// Score each result transaction against the oldest expected value, and record
	// the expected value of each accepted command transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_values.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, value);
					fail_count++;
				end else begin
					exp_value = expected_values.pop_front();
					if (value !== exp_value) begin
						$display("%0t: value mismatch, expected %h, actual %h",
							$time, exp_value, value);
						fail_count++;
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				expected_values.push_back(taylor_value(operation, angle));
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: random stalls, or a long hold when one is requested.
	initial begin : rcv_proc
		int hold_left;
		hold_left = 0;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Offer one command transaction, after a random gap, and hold it until accepted.
	task automatic send_cmd(input logic op, input logic signed [31:0] ang);
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		operation <= op;
		angle <= ang;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_results();
		cmd_valid <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Field extremes and the angles next to +-pi and +-2*pi, for both functions.
	task automatic test_directed();
		logic signed [31:0] dir_angles[11];
		int                 k;
		dir_angles = '{32'sd0, 32'sd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000,
			PI_ANG, PI_ANG + 1, -PI_ANG, -PI_ANG - 1, TWO_PI_ANG, -TWO_PI_ANG - 1};
		for (k = 0; k < 11; k++) begin
			send_cmd(1'b0, dir_angles[k]);
			send_cmd(1'b1, dir_angles[k]);
		end
	endtask

	task automatic test_random(input int snd_pct, input int rcv_pct);
		int k;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			send_cmd($urandom_range(1), rand_angle());
		end
	endtask

	// The result side holds off while commands keep coming, so the unit fills up.
	task automatic test_backpressure();
		int k;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		@(negedge clk);
		hold_req = 1'b1;
		for (k = 0; k < 8; k++) begin
			send_cmd($urandom_range(1), rand_angle());
		end
	endtask

	// The command side pauses until every result is in, then resumes.
	task automatic test_pause_resume();
		int k;
		wait_results();
		for (k = 0; k < 4; k++) begin
			send_cmd($urandom_range(1), rand_angle());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		operation = 1'b0;
		angle = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		snd_idle_pct = 38;
		rcv_idle_pct = 60;
		test_directed();
		test_random(38, 60);
		test_random(60, 38);
		test_random(0, 0);
		test_backpressure();
		test_pause_resume();

		// Let the last results drain, then allow a latency's worth of extra cycles.
		wait_results();
		repeat (LATENCY + 20) @(posedge clk);
		if (fail_count == 0 && expected_values.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
